/* src/ctd_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and the angle table for the crank tooth decoder.
// No dependencies; every other file takes names from here by scope.
package ctd_pkg;

  localparam int TEETH      = 60;
  localparam int LOST_TEETH = 2;
  localparam int RPM_SCALE  = 60;     // seconds per minute
  localparam int ANGLE_FULL = 5760;   // 360 degrees in 1/16 degree

  localparam int SPS_W     = 27;
  localparam int ELAPSED_W = 32;
  localparam int COUNT_W   = 8;
  localparam int RPM_W     = 16;
  localparam int ANGLE_W   = 13;
  localparam int NUM_W     = SPS_W + $clog2(RPM_SCALE);
  localparam int DEN_W     = ELAPSED_W + COUNT_W;
  localparam int STEP_W    = $clog2(NUM_W);
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [SPS_W-1:0]     SPS_RESET = SPS_W'(1000000);
  localparam logic [COUNT_W-1:0]   HALF_TEETH = COUNT_W'(TEETH / 2);
  localparam logic [COUNT_W-1:0]   FULL_TEETH = COUNT_W'(TEETH);
  localparam logic [COUNT_W-1:0]   LOST_COUNT = COUNT_W'(LOST_TEETH);
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

  // one detected change (or the start-up sample), front to back
  typedef struct packed {
    logic                 first;
    logic [COUNT_W-1:0]   count;
    logic [ELAPSED_W-1:0] elapsed;
  } edge_req_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_DONE
  } back_state_t;

  typedef logic [ANGLE_W-1:0] angle_tbl_t [256];

  function automatic angle_tbl_t build_angle_tbl();
    angle_tbl_t tbl;
    for (int i = 0; i < 256; i++) begin
      if (i > TEETH) begin
        tbl[i] = '0;
      end else begin
        tbl[i] = ANGLE_W'(((TEETH - i) * ANGLE_FULL) / TEETH);
      end
    end
    return tbl;
  endfunction

  localparam angle_tbl_t ANGLE_TBL = build_angle_tbl();

endpackage

/* src/ctd_front.sv */
`timescale 1ns / 1ps
// Front end: takes sensor samples, tracks level, tooth count and elapsed samples,
// and queues one request per level change and one at start-up. Uses ctd_pkg.
module ctd_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                smp_valid,
  input  logic                smp_level,
  output logic                smp_ready,
  input  logic                q_full,
  output logic                push_valid,
  output ctd_pkg::edge_req_t  push_data
);

  logic                           started_r, started_nxt;
  logic                           prev_r, prev_nxt;
  logic [ctd_pkg::COUNT_W-1:0]    count_r, count_nxt;
  logic [ctd_pkg::ELAPSED_W-1:0]  elapsed_r, elapsed_nxt;
  logic [ctd_pkg::ELAPSED_W-1:0]  elapsed_inc;
  logic                           take;

  assign smp_ready = !q_full;
  assign take      = smp_valid && smp_ready;
  assign elapsed_inc = (elapsed_r == ctd_pkg::ELAPSED_MAX) ? elapsed_r
                                                            : elapsed_r + 1'b1;

  always_comb begin
    started_nxt = started_r;
    prev_nxt    = prev_r;
    count_nxt   = count_r;
    elapsed_nxt = elapsed_r;
    push_valid  = 1'b0;
    push_data.first   = 1'b0;
    push_data.count   = count_r;
    push_data.elapsed = elapsed_inc;
    if (take) begin
      if (!started_r) begin
        // start-up: preset count, previous level stays as it was
        started_nxt = 1'b1;
        count_nxt   = smp_level ? ctd_pkg::HALF_TEETH : ctd_pkg::LOST_COUNT;
        elapsed_nxt = '0;
        push_valid  = 1'b1;
        push_data.first   = 1'b1;
        push_data.count   = count_nxt;
        push_data.elapsed = '0;
      end else if (smp_level != prev_r) begin
        if (count_r == ctd_pkg::FULL_TEETH) begin
          count_nxt = ctd_pkg::LOST_COUNT;
        end else if (smp_level) begin
          count_nxt = count_r + 1'b1;
        end
        prev_nxt    = smp_level;
        elapsed_nxt = '0;
        push_valid  = 1'b1;
        push_data.count = count_nxt;
      end else begin
        elapsed_nxt = elapsed_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r <= 1'b0;
      prev_r    <= 1'b0;
      count_r   <= '0;
      elapsed_r <= '0;
    end else begin
      started_r <= started_nxt;
      prev_r    <= prev_nxt;
      count_r   <= count_nxt;
      elapsed_r <= elapsed_nxt;
    end
  end

endmodule

/* src/ctd_queue.sv */
`timescale 1ns / 1ps
// Short request queue between front and back end.
// Uses ctd_pkg for the entry type and depth.
module ctd_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  input  ctd_pkg::edge_req_t  push_data,
  output logic                full,
  input  logic                pop_ready,
  output logic                pop_valid,
  output ctd_pkg::edge_req_t  pop_data
);

  ctd_pkg::edge_req_t             mem_r [ctd_pkg::QUEUE_DEPTH];
  logic [ctd_pkg::QUEUE_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [ctd_pkg::QUEUE_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [ctd_pkg::QUEUE_AW:0]     fill_r, fill_nxt;
  logic                           do_push, do_pop;

  assign full      = (fill_r == (ctd_pkg::QUEUE_AW+1)'(ctd_pkg::QUEUE_DEPTH));
  assign pop_valid = (fill_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];
  assign do_push   = push_valid && !full;
  assign do_pop    = pop_ready && pop_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

endmodule

/* src/ctd_back.sv */
`timescale 1ns / 1ps
// Back end: per change request computes rpm with a bit-serial restoring divider,
// looks up the angle (both zero at start-up) and registers the result. Uses ctd_pkg.
module ctd_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [ctd_pkg::SPS_W-1:0]     sps,
  input  logic                          req_valid,
  input  ctd_pkg::edge_req_t            req_data,
  output logic                          req_ready,
  output logic                          res_valid,
  input  logic                          res_ready,
  output logic                          res_first,
  output logic [ctd_pkg::COUNT_W-1:0]   res_count,
  output logic                          res_tick,
  output logic [ctd_pkg::RPM_W-1:0]     res_rpm,
  output logic [ctd_pkg::ANGLE_W-1:0]   res_angle
);

  ctd_pkg::back_state_t           state_r, state_nxt;
  logic [ctd_pkg::STEP_W-1:0]     step_r, step_nxt;
  logic [ctd_pkg::NUM_W-1:0]      quo_r, quo_nxt;
  logic [ctd_pkg::DEN_W-1:0]      rem_r, rem_nxt;
  logic [ctd_pkg::DEN_W-1:0]      den_r, den_nxt;
  logic                           first_r, first_nxt;
  logic [ctd_pkg::COUNT_W-1:0]    cnt_r, cnt_nxt;
  logic                           ovalid_r, ovalid_nxt;
  logic                           ofirst_r, ofirst_nxt;
  logic [ctd_pkg::COUNT_W-1:0]    ocount_r, ocount_nxt;
  logic                           otick_r, otick_nxt;
  logic [ctd_pkg::RPM_W-1:0]      orpm_r, orpm_nxt;
  logic [ctd_pkg::ANGLE_W-1:0]    oangle_r, oangle_nxt;
  logic [ctd_pkg::DEN_W:0]        trial;
  logic                           fits;
  logic                           out_free;
  logic [ctd_pkg::RPM_W-1:0]      rpm_sat;

  assign out_free = !ovalid_r || res_ready;
  assign trial    = {rem_r, quo_r[ctd_pkg::NUM_W-1]};
  assign fits     = (trial >= {1'b0, den_r});
  assign rpm_sat  = (|quo_r[ctd_pkg::NUM_W-1:ctd_pkg::RPM_W]) ? '1
                                                               : quo_r[ctd_pkg::RPM_W-1:0];

  always_comb begin
    state_nxt  = state_r;
    step_nxt   = step_r;
    quo_nxt    = quo_r;
    rem_nxt    = rem_r;
    den_nxt    = den_r;
    first_nxt  = first_r;
    cnt_nxt    = cnt_r;
    ovalid_nxt = ovalid_r && !res_ready;
    ofirst_nxt = ofirst_r;
    ocount_nxt = ocount_r;
    otick_nxt  = otick_r;
    orpm_nxt   = orpm_r;
    oangle_nxt = oangle_r;
    req_ready  = 1'b0;
    case (state_r)
      ctd_pkg::BK_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          first_nxt = req_data.first;
          cnt_nxt   = req_data.count;
          rem_nxt   = '0;
          step_nxt  = '0;
          den_nxt   = ctd_pkg::DEN_W'(req_data.elapsed) * ctd_pkg::DEN_W'(ctd_pkg::TEETH);
          if (req_data.first) begin
            quo_nxt   = '0;
            state_nxt = ctd_pkg::BK_DONE;
          end else begin
            // dividend 60 * sample rate, shifted out MSB first
            quo_nxt   = ctd_pkg::NUM_W'(sps) * ctd_pkg::NUM_W'(ctd_pkg::RPM_SCALE);
            state_nxt = ctd_pkg::BK_DIV;
          end
        end
      end
      ctd_pkg::BK_DIV: begin
        rem_nxt  = fits ? ctd_pkg::DEN_W'(trial - {1'b0, den_r})
                        : trial[ctd_pkg::DEN_W-1:0];
        quo_nxt  = {quo_r[ctd_pkg::NUM_W-2:0], fits};
        step_nxt = step_r + 1'b1;
        if (step_r == ctd_pkg::STEP_W'(ctd_pkg::NUM_W - 1)) begin
          state_nxt = ctd_pkg::BK_DONE;
        end
      end
      ctd_pkg::BK_DONE: begin
        if (out_free) begin
          ovalid_nxt = 1'b1;
          ofirst_nxt = first_r;
          ocount_nxt = cnt_r;
          otick_nxt  = !first_r &&
                       (cnt_r == ctd_pkg::HALF_TEETH || cnt_r == ctd_pkg::FULL_TEETH);
          orpm_nxt   = first_r ? '0 : rpm_sat;
          oangle_nxt = first_r ? '0 : ctd_pkg::ANGLE_TBL[cnt_r];
          state_nxt  = ctd_pkg::BK_IDLE;
        end
      end
      default: begin
        state_nxt = ctd_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ctd_pkg::BK_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r   <= step_nxt;
    quo_r    <= quo_nxt;
    rem_r    <= rem_nxt;
    den_r    <= den_nxt;
    first_r  <= first_nxt;
    cnt_r    <= cnt_nxt;
    ofirst_r <= ofirst_nxt;
    ocount_r <= ocount_nxt;
    otick_r  <= otick_nxt;
    orpm_r   <= orpm_nxt;
    oangle_r <= oangle_nxt;
  end

  assign res_valid = ovalid_r;
  assign res_first = ofirst_r;
  assign res_count = ocount_r;
  assign res_tick  = otick_r;
  assign res_rpm   = orpm_r;
  assign res_angle = oangle_r;

endmodule

/* src/crank_tooth_decoder_core.sv */
`timescale 1ns / 1ps
// Crank tooth decoder top level: front end, request queue, back end, config register.
// Depends on ctd_pkg, ctd_front, ctd_queue and ctd_back.
//
// One sensor sample is taken per cycle while the request queue (4 entries) has
// room. The first sample after reset and every later level change each yield
// one result; other samples yield none. A change result holds the back end while
// it takes the request, runs the bit-serial divider that forms rpm one quotient
// bit per cycle over 33 dividend bits, and loads the output register once the
// output is free; a start-up result skips the divider. Changes arriving faster
// than the back end finishes them fill the queue; in_tready drops while it is full.
// rpm = 60*samples_per_second/(elapsed*TEETH), saturating at 65535.
module crank_tooth_decoder_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [26:0] cfg_wr_data,   // samples_per_second
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,      // [0] sensor_level, [7:1] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,     // [7:0] tooth_count, [8] tdc_tick,
                                     // [24:9] engine_rpm, [37:25] angle_before_tdc
  output logic        out_tuser      // [0] first_sample
);

  logic [ctd_pkg::SPS_W-1:0]     sps_r;
  logic                          push_valid, q_full, pop_ready, pop_valid;
  ctd_pkg::edge_req_t            push_data, pop_data;
  logic [ctd_pkg::COUNT_W-1:0]   res_count;
  logic                          res_tick;
  logic [ctd_pkg::RPM_W-1:0]     res_rpm;
  logic [ctd_pkg::ANGLE_W-1:0]   res_angle;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sps_r <= ctd_pkg::SPS_RESET;
    end else if (cfg_wr_en) begin
      sps_r <= cfg_wr_data;
    end
  end

  ctd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .smp_valid  (in_tvalid),
    .smp_level  (in_tdata[0]),
    .smp_ready  (in_tready),
    .q_full     (q_full),
    .push_valid (push_valid),
    .push_data  (push_data)
  );

  ctd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  (push_data),
    .full       (q_full),
    .pop_ready  (pop_ready),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data)
  );

  ctd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .sps       (sps_r),
    .req_valid (pop_valid),
    .req_data  (pop_data),
    .req_ready (pop_ready),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res_first (out_tuser),
    .res_count (res_count),
    .res_tick  (res_tick),
    .res_rpm   (res_rpm),
    .res_angle (res_angle)
  );

  assign out_tdata = {2'b00, res_angle, res_rpm, res_tick, res_count};

endmodule
